/* hw/rtl/ibma_pkg.sv */
// Shared types and constants for the box association block.
// Used by ibma_cell, ibma_overlap and iou_best_match_association_core.
package ibma_pkg;

    localparam int MAX_CAMERA_BOXES = 32;
    localparam int IDX_W = $clog2(MAX_CAMERA_BOXES);
    localparam int CNT_W = $clog2(MAX_CAMERA_BOXES + 1);
    localparam int OUT_IDX_W = 5;
    localparam int AREA_W = 24;
    localparam int UNION_W = 25;
    localparam int THR_W = 16;
    localparam int IN_TDATA_W = 64;
    localparam int OUT_TDATA_W = 16;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_MATCH = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    localparam logic [2:0] COLOR_UNKNOWN = 3'd5;
    localparam logic [7:0] CLASS_MAX = 8'd4;
    localparam logic [THR_W-1:0] THR_RESET = 16'd32768;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_LISTING = 1'b1;

    typedef struct packed {
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic [11:0]        width;
        logic [11:0]        height;
        logic [7:0]         cls;
        logic               has_cls;
    } ibma_box_t;

    // One overlap candidate leaving the overlap unit.
    typedef struct packed {
        logic                 valid;
        logic [AREA_W-1:0]    inter;
        logic [UNION_W-1:0]   uni;
        logic [IDX_W-1:0]     idx;
        logic [7:0]           cls;
        logic                 has_cls;
    } ibma_cand_t;

    typedef struct packed {
        logic                 kind;
        logic [2:0]           color;
        logic                 found;
        logic [OUT_IDX_W-1:0] best_index;
        logic [OUT_IDX_W-1:0] unmatched_index;
        logic                 list_empty;
        logic                 last;
    } ibma_result_t;

endpackage

/* hw/rtl/ibma_cell.sv */
// One table cell of the rotating camera box ring.
// Depends on ibma_pkg for the box type.
module ibma_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  logic              load_en,
    input  ibma_pkg::ibma_box_t load_box,
    input  logic              set_match,
    input  logic              clear_match,
    input  ibma_pkg::ibma_box_t nbr_box,
    input  logic              nbr_matched,
    output ibma_pkg::ibma_box_t box,
    output logic              matched
);

    ibma_pkg::ibma_box_t box_reg;
    logic matched_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            box_reg <= nbr_box;
        end
        else if (load_en)
        begin
            box_reg <= load_box;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            matched_reg <= nbr_matched;
        end
        else if (load_en || clear_match)
        begin
            matched_reg <= 1'b0;
        end
        else if (set_match)
        begin
            matched_reg <= 1'b1;
        end
    end

    assign box = box_reg;
    assign matched = matched_reg;

endmodule

/* hw/rtl/ibma_overlap.sv */
// Three-stage overlap unit: intersection extents, areas, then union.
// Depends on ibma_pkg for the box and candidate types.
module ibma_overlap (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          act,
    input  logic [ibma_pkg::IDX_W-1:0]    idx,
    input  ibma_pkg::ibma_box_t           probe,
    input  logic [ibma_pkg::AREA_W-1:0]   probe_area,
    input  ibma_pkg::ibma_box_t           entry,
    output ibma_pkg::ibma_cand_t          cand
);

    function automatic logic [ibma_pkg::UNION_W-1:0] UNION_W_SUM(
        input logic [ibma_pkg::AREA_W-1:0] a,
        input logic [ibma_pkg::AREA_W-1:0] b
    );
        UNION_W_SUM = {1'b0, a} + {1'b0, b};
    endfunction

    logic signed [13:0] pl, pr, pt, pb, el, er, et, eb;
    logic signed [13:0] x1, x2, y1, y2, dx, dy;
    logic overlap;

    logic a_valid_reg;
    logic [11:0] a_iw_reg, a_ih_reg, a_bw_reg, a_bh_reg;
    logic [ibma_pkg::IDX_W-1:0] a_idx_reg, b_idx_reg;
    logic [7:0] a_cls_reg, b_cls_reg;
    logic a_has_reg, b_has_reg;

    logic b_valid_reg;
    logic [ibma_pkg::AREA_W-1:0] b_inter_reg, b_area_reg;

    ibma_pkg::ibma_cand_t c_reg;
    ibma_pkg::ibma_cand_t c_next;

    always_comb
    begin
        pl = 14'(probe.left);
        pt = 14'(probe.top);
        pr = pl + $signed({2'b00, probe.width});
        pb = pt + $signed({2'b00, probe.height});
        el = 14'(entry.left);
        et = 14'(entry.top);
        er = el + $signed({2'b00, entry.width});
        eb = et + $signed({2'b00, entry.height});
        x1 = (pl > el) ? pl : el;
        y1 = (pt > et) ? pt : et;
        x2 = (pr < er) ? pr : er;
        y2 = (pb < eb) ? pb : eb;
        dx = x2 - x1;
        dy = y2 - y1;
        overlap = (x2 > x1) && (y2 > y1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_reg <= '0;
        end
        else
        begin
            a_valid_reg <= act && overlap;
            b_valid_reg <= a_valid_reg;
            c_reg <= c_next;
        end
    end

    // Only boxes with a non-empty intersection are marked valid, so a valid candidate's inter is never zero.
    always_ff @(posedge clk)
    begin
        a_iw_reg <= dx[11:0];
        a_ih_reg <= dy[11:0];
        a_bw_reg <= entry.width;
        a_bh_reg <= entry.height;
        a_idx_reg <= idx;
        a_cls_reg <= entry.cls;
        a_has_reg <= entry.has_cls;
        b_inter_reg <= a_iw_reg * a_ih_reg;
        b_area_reg <= a_bw_reg * a_bh_reg;
        b_idx_reg <= a_idx_reg;
        b_cls_reg <= a_cls_reg;
        b_has_reg <= a_has_reg;
    end

    always_comb
    begin
        c_next.valid = b_valid_reg;
        c_next.inter = b_inter_reg;
        c_next.uni = UNION_W_SUM(probe_area, b_area_reg) - {1'b0, b_inter_reg};
        c_next.idx = b_idx_reg;
        c_next.cls = b_cls_reg;
        c_next.has_cls = b_has_reg;
    end

    assign cand = c_reg;

endmodule

/* hw/rtl/iou_best_match_association_core.sv */
// Greedy best-overlap association: top level with ring, scan control and output register.
// Depends on ibma_pkg, ibma_cell and ibma_overlap.
//
// Camera boxes sit in a ring of cells that rotates one place per cycle, unless
// stalled, past a single pipelined overlap unit. A load writes the next free
// cell and keeps the input open. A match rotates the full ring once (one entry
// per cycle, whatever the entry count), drains the three-stage overlap unit,
// checks the threshold, and emits its answer when the output register is free;
// the input reopens as that answer appears at the output. A report also
// rotates the ring once, emitting one word per unmatched entry (a list_empty
// word if none) and clearing the table; it stalls while the output word is
// not taken. Configuration writes may happen at any time the block is idle.
module iou_best_match_association_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [ibma_pkg::THR_W-1:0]           cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // box_left, box_top, box_width, box_height, class_label, has_class,
    // box_valid, 4 zero bits
    input  logic [ibma_pkg::IN_TDATA_W-1:0]      s_tdata,
    // operation
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // cone_color, match_found, best_index, unmatched_index, list_empty, 1 zero bit
    output logic [ibma_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // result_kind
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    localparam int MAX = ibma_pkg::MAX_CAMERA_BOXES;
    localparam int IDX_W = ibma_pkg::IDX_W;
    localparam int CNT_W = ibma_pkg::CNT_W;
    localparam int OIW = ibma_pkg::OUT_IDX_W;

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_SCAN       = 7'b0000010,
        ST_DRAIN      = 7'b0000100,
        ST_THRESH     = 7'b0001000,
        ST_MATCH_OUT  = 7'b0010000,
        ST_REPORT     = 7'b0100000,
        ST_REPORT_END = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [ibma_pkg::THR_W-1:0] thr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [1:0] drain_reg, drain_next;

    ibma_pkg::ibma_box_t probe_reg;
    logic probe_valid_reg;
    logic [ibma_pkg::AREA_W-1:0] probe_area_reg;

    logic [ibma_pkg::AREA_W-1:0] best_in_reg, best_in_next;
    logic [ibma_pkg::UNION_W-1:0] best_un_reg, best_un_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [7:0] best_cls_reg, best_cls_next;
    logic best_has_reg, best_has_next;
    logic found_reg, found_next;

    logic pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;

    logic out_valid_reg;
    ibma_pkg::ibma_result_t out_reg, out_data;
    logic out_load, out_free;

    ibma_pkg::ibma_box_t in_box, cell_box [MAX];
    logic cell_matched [MAX];
    logic ring_shift, load_fire, set_match, clear_all, cand_here, step_ok;
    logic overlap_act;
    ibma_pkg::ibma_cand_t cand;
    logic [48:0] lhs_prod, rhs_prod;
    logic [41:0] thr_lhs, thr_rhs;
    logic in_fire;

    assign in_box.left = $signed(s_tdata[12:0]);
    assign in_box.top = $signed(s_tdata[25:13]);
    assign in_box.width = s_tdata[37:26];
    assign in_box.height = s_tdata[49:38];
    assign in_box.cls = s_tdata[57:50];
    assign in_box.has_cls = s_tdata[58];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire = s_tvalid && s_tready;
    assign load_fire = in_fire && (s_tuser == ibma_pkg::OP_LOAD)
        && (count_reg < CNT_W'(MAX));
    assign out_free = !out_valid_reg || m_tready;

    genvar gi;
    generate
        for (gi = 0; gi < MAX; gi++)
        begin : g_ring
            ibma_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift_en    (ring_shift),
                .load_en     (load_fire && (count_reg == CNT_W'(gi))),
                .load_box    (in_box),
                .set_match   (set_match && (best_idx_reg == IDX_W'(gi))),
                .clear_match (clear_all),
                .nbr_box     (cell_box[(gi + 1) % MAX]),
                .nbr_matched (cell_matched[(gi + 1) % MAX]),
                .box         (cell_box[gi]),
                .matched     (cell_matched[gi])
            );
        end
    endgenerate

    assign overlap_act = (state_reg == ST_SCAN) && probe_valid_reg
        && (CNT_W'(pos_reg) < count_reg);

    ibma_overlap u_overlap (
        .clk        (clk),
        .rst_n      (rst_n),
        .act        (overlap_act),
        .idx        (pos_reg),
        .probe      (probe_reg),
        .probe_area (probe_area_reg),
        .entry      (cell_box[0]),
        .cand       (cand)
    );

    // Exact ratio compare: inter/uni > best_in/best_un.
    assign lhs_prod = cand.inter * best_un_reg;
    assign rhs_prod = best_in_reg * cand.uni;
    assign thr_lhs = {2'b00, best_in_reg, 16'd0};
    assign thr_rhs = 42'(thr_reg) * 42'(best_un_reg);

    assign cand_here = (CNT_W'(pos_reg) < count_reg) && !cell_matched[0];
    assign step_ok = !(cand_here && pend_valid_reg && !out_free);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        drain_next = drain_reg;
        best_in_next = best_in_reg;
        best_un_next = best_un_reg;
        best_idx_next = best_idx_reg;
        best_cls_next = best_cls_reg;
        best_has_next = best_has_reg;
        found_next = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next = pend_idx_reg;
        ring_shift = 1'b0;
        set_match = 1'b0;
        clear_all = 1'b0;
        out_load = 1'b0;
        out_data = '0;

        if (cand.valid && (lhs_prod > rhs_prod))
        begin
            best_in_next = cand.inter;
            best_un_next = cand.uni;
            best_idx_next = cand.idx;
            best_cls_next = cand.cls;
            best_has_next = cand.has_cls;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (load_fire)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (in_fire && (s_tuser == ibma_pkg::OP_MATCH))
                begin
                    best_in_next = '0;
                    best_un_next = ibma_pkg::UNION_W'(1);
                    best_idx_next = '0;
                    pos_next = '0;
                    state_next = ST_SCAN;
                end
                if (in_fire && (s_tuser == ibma_pkg::OP_REPORT))
                begin
                    pos_next = '0;
                    pend_valid_next = 1'b0;
                    state_next = ST_REPORT;
                end
            end
            ST_SCAN:
            begin
                ring_shift = 1'b1;
                if (pos_reg == IDX_W'(MAX - 1))
                begin
                    pos_next = '0;
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                begin
                    state_next = ST_THRESH;
                end
            end
            ST_THRESH:
            begin
                found_next = (thr_lhs > thr_rhs);
                state_next = ST_MATCH_OUT;
            end
            ST_MATCH_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_data.kind = ibma_pkg::KIND_MATCH;
                    out_data.color = ibma_pkg::COLOR_UNKNOWN;
                    out_data.last = 1'b1;
                    if (found_reg)
                    begin
                        set_match = 1'b1;
                        out_data.found = 1'b1;
                        out_data.best_index = OIW'(best_idx_reg);
                        if (best_has_reg && (best_cls_reg <= ibma_pkg::CLASS_MAX))
                        begin
                            out_data.color = best_cls_reg[2:0];
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_REPORT:
            begin
                // The previous candidate is sent once the next one is found, so
                // only the final word carries last.
                if (step_ok)
                begin
                    ring_shift = 1'b1;
                    if (cand_here)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load = 1'b1;
                            out_data.kind = ibma_pkg::KIND_LISTING;
                            out_data.unmatched_index = OIW'(pend_idx_reg);
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next = pos_reg;
                    end
                    if (pos_reg == IDX_W'(MAX - 1))
                    begin
                        pos_next = '0;
                        state_next = ST_REPORT_END;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_REPORT_END:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_data.kind = ibma_pkg::KIND_LISTING;
                    out_data.last = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_data.unmatched_index = OIW'(pend_idx_reg);
                    end
                    else
                    begin
                        out_data.list_empty = 1'b1;
                    end
                    clear_all = 1'b1;
                    count_next = '0;
                    pend_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thr_reg <= ibma_pkg::THR_RESET;
            count_reg <= '0;
            pos_reg <= '0;
            drain_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            pos_reg <= pos_next;
            drain_reg <= drain_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            probe_reg <= in_box;
            probe_valid_reg <= s_tdata[59];
            probe_area_reg <= in_box.width * in_box.height;
        end
        best_in_reg <= best_in_next;
        best_un_reg <= best_un_next;
        best_idx_reg <= best_idx_next;
        best_cls_reg <= best_cls_next;
        best_has_reg <= best_has_next;
        found_reg <= found_next;
        pend_idx_reg <= pend_idx_next;
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_reg.kind;
    assign m_tlast = out_reg.last;
    assign m_tdata = {1'b0, out_reg.list_empty, out_reg.unmatched_index,
                      out_reg.best_index, out_reg.found, out_reg.color};

    // The ring must be back at its home position whenever the block is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (pos_reg == '0))
        else $error("ring not at home position while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output word overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX))
        else $error("entry count beyond table capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_REPORT_END) && out_free) |=> (count_reg == '0))
        else $error("table not cleared after report");

endmodule
